// ===== hdl/grid_surface_interpolator_unit_assert.svh =====
// assertion macros for the grid surface interpolator
`ifndef GRID_SURFACE_INTERPOLATOR_UNIT_ASSERT_SVH
`define GRID_SURFACE_INTERPOLATOR_UNIT_ASSERT_SVH

// checked outside reset
`define GSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define GSI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/gsi_pkg.sv =====
package gsi_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_Y_ORIGIN       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_ORIGIN       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_CELL_H     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_CELL_W     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_IN_USE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS_IN_USE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERP_MODE    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_NO_DATA_POLICY = 3'd7;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic FACE_NEG = 1'b0;
   localparam logic FACE_POS = 1'b1;

   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   localparam logic [1:0] POLICY_OUTSIDE = 2'd0;
   localparam logic [1:0] POLICY_INSIDE  = 2'd1;
   localparam logic [1:0] POLICY_ERROR   = 2'd2;

   localparam int INSIDE_HALF = 409;
   localparam int HALF_CELL   = 128;
   localparam int WEIGHT_ONE  = 256;
   localparam int POS_SHIFT   = 16;
   localparam int BOX_SHIFT   = 24;

   typedef struct packed {
      logic [23:0] y_origin;
      logic [23:0] z_origin;
      logic [19:0] inv_h;
      logic [19:0] inv_w;
      logic [6:0]  rows;
      logic [7:0]  cols;
      logic        mode;
      logic [1:0]  policy;
   } cfg_type;

   typedef struct packed {
      logic       nearest;
      logic [7:0] ty;
      logic [7:0] tz;
      logic       ra_odd;
      logic       rb_odd;
      logic       ca_odd;
      logic       cb_odd;
   } blend_ctl_type;

endpackage

// ===== hdl/grid_surface_interpolator_unit.sv =====
// grid surface interpolator: two face grids, queried at (y,z) per item
// req channel: one item per transfer; opcode selects a grid load (writes one
//   entry of the chosen face, gives no result) or a query (gives one result)
// rsp channel: one result per query, in order: face values, midpoint, gap,
//   containment of query_x and the no-data error flag
// csr channel: register index and data; csr_ready is always high, write only
//   while no item is in flight
// one item per cycle is taken unless rsp_stall freezes the pipeline, set by
//   four bank reads per face each cycle (rows and columns split by parity
//   so the four corners never share a bank)
// a load is seen by any query taken after it
// reset clears the registers to their defaults and empties the pipeline;
//   grid contents are undefined until loaded
// rsp_stall freezes the whole pipeline and raises req_stall while a result
//   waits; req_stall never rises otherwise
module grid_surface_interpolator_unit #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 128,
   parameter int COORD_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic                                   req_face_select,
   input  logic [5:0]                             req_load_row,
   input  logic [6:0]                             req_load_col,
   input  logic signed [COORD_BITS-1:0]           req_load_value,
   input  logic                                   req_load_has_data,
   input  logic signed [COORD_BITS-1:0]           req_query_y,
   input  logic signed [COORD_BITS-1:0]           req_query_z,
   input  logic signed [COORD_BITS-1:0]           req_query_x,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_in_box,
   output logic signed [COORD_BITS-1:0]           rsp_neg_face_x,
   output logic                                   rsp_neg_face_valid,
   output logic signed [COORD_BITS-1:0]           rsp_pos_face_x,
   output logic                                   rsp_pos_face_valid,
   output logic signed [COORD_BITS-1:0]           rsp_mid_x,
   output logic signed [COORD_BITS:0]             rsp_face_gap,
   output logic                                   rsp_contained,
   output logic                                   rsp_no_data_error,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gsi_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [gsi_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int CB    = COORD_BITS;
   localparam int ROW_W = (MAX_ROWS > 4) ? $clog2(MAX_ROWS) : 2;
   localparam int COL_W = (MAX_COLS > 4) ? $clog2(MAX_COLS) : 2;
   localparam int AW    = ROW_W + COL_W - 2;
   localparam int EW    = CB + 1;
   localparam logic signed [CB-1:0] INSIDE_HI = CB'(gsi_pkg::INSIDE_HALF);
   localparam logic signed [CB-1:0] INSIDE_LO = CB'(-gsi_pkg::INSIDE_HALF);

   gsi_pkg::cfg_type cfg_ff;
   logic en, accept;

   logic                 s1_v_ff, s2_v_ff, s3_v_ff;
   logic                 s1_op_ff, s2_op_ff, s3_op_ff;
   logic                 s1_face_ff, s2_face_ff, s3_face_ff;
   logic [5:0]           s1_row_ff, s2_row_ff, s3_row_ff;
   logic [6:0]           s1_col_ff, s2_col_ff, s3_col_ff;
   logic signed [CB-1:0] s1_val_ff, s2_val_ff, s3_val_ff;
   logic                 s1_has_ff, s2_has_ff, s3_has_ff;
   logic signed [CB-1:0] s1_y_ff, s1_z_ff;
   logic signed [CB-1:0] s1_x_ff, s2_x_ff, s3_x_ff;

   logic [3:0]           tail_v_ff, tail_q_ff, tail_ib_ff;
   logic signed [CB-1:0] tail_x_ff [4];

   logic                         in_box;
   logic [3:0][AW-1:0]           raddr;
   gsi_pkg::blend_ctl_type       ctl, ctl4_ff;

   logic [31:0]          lr32, lc32;
   logic [ROW_W-1:0]     lr;
   logic [COL_W-1:0]     lc;
   logic                 load_we, we_neg, we_pos;
   logic [1:0]           wbank;
   logic [AW-1:0]        waddr;
   logic [EW-1:0]        wdata;
   logic [3:0][EW-1:0]   neg_rdata, pos_rdata;

   logic signed [CB-1:0] neg_x, pos_x;
   logic                 neg_ok, pos_ok;

   logic                 ib7, both;
   logic signed [CB:0]   pair_sum, gap_in;
   logic signed [CB-1:0] mid_in, x7;
   logic                 cont_in, err_in;

   logic                 rsp_valid_ff;
   logic                 rsp_in_box_ff, rsp_neg_valid_ff, rsp_pos_valid_ff;
   logic signed [CB-1:0] rsp_neg_x_ff, rsp_pos_x_ff, rsp_mid_x_ff;
   logic signed [CB:0]   rsp_gap_ff;
   logic                 rsp_cont_ff, rsp_err_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && en;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.y_origin <= '0;
         cfg_ff.z_origin <= '0;
         cfg_ff.inv_h    <= 20'd65536;
         cfg_ff.inv_w    <= 20'd65536;
         cfg_ff.rows     <= 7'd64;
         cfg_ff.cols     <= 8'd128;
         cfg_ff.mode     <= gsi_pkg::MODE_BILINEAR;
         cfg_ff.policy   <= gsi_pkg::POLICY_OUTSIDE;
      end else if (csr_valid) begin
         unique case (csr_index)
            gsi_pkg::REG_Y_ORIGIN:       cfg_ff.y_origin <= csr_data;
            gsi_pkg::REG_Z_ORIGIN:       cfg_ff.z_origin <= csr_data;
            gsi_pkg::REG_INV_CELL_H:     cfg_ff.inv_h    <= csr_data[19:0];
            gsi_pkg::REG_INV_CELL_W:     cfg_ff.inv_w    <= csr_data[19:0];
            gsi_pkg::REG_ROWS_IN_USE:    cfg_ff.rows     <= csr_data[6:0];
            gsi_pkg::REG_COLS_IN_USE:    cfg_ff.cols     <= csr_data[7:0];
            gsi_pkg::REG_INTERP_MODE:    cfg_ff.mode     <= csr_data[0];
            gsi_pkg::REG_NO_DATA_POLICY: cfg_ff.policy   <= csr_data[1:0];
         endcase
      end
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         tail_v_ff <= '0;
      end else if (en) begin
         s1_v_ff   <= accept;
         s2_v_ff   <= s1_v_ff;
         s3_v_ff   <= s2_v_ff;
         tail_v_ff <= {tail_v_ff[2:0], s3_v_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff   <= req_opcode;
         s1_face_ff <= req_face_select;
         s1_row_ff  <= req_load_row;
         s1_col_ff  <= req_load_col;
         s1_val_ff  <= req_load_value;
         s1_has_ff  <= req_load_has_data;
         s1_y_ff    <= req_query_y;
         s1_z_ff    <= req_query_z;
         s1_x_ff    <= req_query_x;
         s2_op_ff   <= s1_op_ff;
         s2_face_ff <= s1_face_ff;
         s2_row_ff  <= s1_row_ff;
         s2_col_ff  <= s1_col_ff;
         s2_val_ff  <= s1_val_ff;
         s2_has_ff  <= s1_has_ff;
         s2_x_ff    <= s1_x_ff;
         s3_op_ff   <= s2_op_ff;
         s3_face_ff <= s2_face_ff;
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         s3_val_ff  <= s2_val_ff;
         s3_has_ff  <= s2_has_ff;
         s3_x_ff    <= s2_x_ff;
         tail_q_ff  <= {tail_q_ff[2:0], s3_op_ff == gsi_pkg::OP_QUERY};
         tail_ib_ff <= {tail_ib_ff[2:0], in_box};
         tail_x_ff[0] <= s3_x_ff;
         for (int i = 1; i < 4; i++) begin
            tail_x_ff[i] <= tail_x_ff[i-1];
         end
         ctl4_ff    <= ctl;
      end
   end

   gsi_addr #(
      .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .COORD_BITS(CB),
      .ROW_W(ROW_W), .COL_W(COL_W), .AW(AW)
   ) u_addr (
      .clock (clock),
      .en    (en),
      .cfg   (cfg_ff),
      .qy    (s1_y_ff),
      .qz    (s1_z_ff),
      .in_box(in_box),
      .raddr (raddr),
      .ctl   (ctl)
   );

   // loads write in the same stage that queries read, so order is kept
   assign lr32    = 32'(s3_row_ff);
   assign lc32    = 32'(s3_col_ff);
   assign lr      = lr32[ROW_W-1:0];
   assign lc      = lc32[COL_W-1:0];
   assign load_we = s3_v_ff && (s3_op_ff == gsi_pkg::OP_LOAD)
                    && (lr32 < 32'(MAX_ROWS)) && (lc32 < 32'(MAX_COLS));
   assign we_neg  = load_we && (s3_face_ff == gsi_pkg::FACE_NEG);
   assign we_pos  = load_we && (s3_face_ff == gsi_pkg::FACE_POS);
   assign wbank   = {lr[0], lc[0]};
   assign waddr   = {lr[ROW_W-1:1], lc[COL_W-1:1]};
   assign wdata   = {s3_has_ff, s3_val_ff};

   gsi_grid #(.AW(AW), .EW(EW)) u_neg_grid (
      .clock(clock), .en(en), .we(we_neg), .wbank(wbank), .waddr(waddr),
      .wdata(wdata), .raddr(raddr), .rdata(neg_rdata)
   );

   gsi_grid #(.AW(AW), .EW(EW)) u_pos_grid (
      .clock(clock), .en(en), .we(we_pos), .wbank(wbank), .waddr(waddr),
      .wdata(wdata), .raddr(raddr), .rdata(pos_rdata)
   );

   gsi_blend #(.COORD_BITS(CB)) u_neg_blend (
      .clock(clock), .en(en), .ctl(ctl4_ff), .rdata(neg_rdata),
      .face_x(neg_x), .face_ok(neg_ok)
   );

   gsi_blend #(.COORD_BITS(CB)) u_pos_blend (
      .clock(clock), .en(en), .ctl(ctl4_ff), .rdata(pos_rdata),
      .face_x(pos_x), .face_ok(pos_ok)
   );

   // result assembly
   assign ib7      = tail_ib_ff[3];
   assign x7       = tail_x_ff[3];
   assign both     = ib7 && neg_ok && pos_ok;
   assign pair_sum = (CB+1)'(neg_x) + (CB+1)'(pos_x);
   assign mid_in   = CB'((pair_sum + (CB+1)'(pair_sum[CB])) >>> 1);
   assign gap_in   = (CB+1)'(pos_x) - (CB+1)'(neg_x);

   always_comb begin
      cont_in = 1'b0;
      err_in  = 1'b0;
      if (both) begin
         cont_in = (x7 >= neg_x) && (x7 <= pos_x);
      end else if (ib7 && (cfg_ff.policy == gsi_pkg::POLICY_INSIDE)) begin
         cont_in = (x7 >= INSIDE_LO) && (x7 <= INSIDE_HI);
      end else if (ib7 && (cfg_ff.policy == gsi_pkg::POLICY_ERROR)) begin
         err_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= tail_v_ff[3] && tail_q_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_in_box_ff    <= ib7;
         rsp_neg_valid_ff <= ib7 && neg_ok;
         rsp_pos_valid_ff <= ib7 && pos_ok;
         rsp_neg_x_ff     <= (ib7 && neg_ok) ? neg_x : '0;
         rsp_pos_x_ff     <= (ib7 && pos_ok) ? pos_x : '0;
         rsp_mid_x_ff     <= both ? mid_in : '0;
         rsp_gap_ff       <= both ? gap_in : '0;
         rsp_cont_ff      <= cont_in;
         rsp_err_ff       <= err_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_in_box         = rsp_in_box_ff;
   assign rsp_neg_face_x     = rsp_neg_x_ff;
   assign rsp_neg_face_valid = rsp_neg_valid_ff;
   assign rsp_pos_face_x     = rsp_pos_x_ff;
   assign rsp_pos_face_valid = rsp_pos_valid_ff;
   assign rsp_mid_x          = rsp_mid_x_ff;
   assign rsp_face_gap       = rsp_gap_ff;
   assign rsp_contained      = rsp_cont_ff;
   assign rsp_no_data_error  = rsp_err_ff;

endmodule

// ===== hdl/gsi_addr.sv =====
module gsi_addr #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 128,
   parameter int COORD_BITS = 24,
   parameter int ROW_W      = 6,
   parameter int COL_W      = 7,
   parameter int AW         = 11
) (
   input  logic                          clock,
   input  logic                          en,
   input  gsi_pkg::cfg_type              cfg,
   input  logic signed [COORD_BITS-1:0]  qy,
   input  logic signed [COORD_BITS-1:0]  qz,
   output logic                          in_box,
   output logic [3:0][AW-1:0]            raddr,
   output gsi_pkg::blend_ctl_type        ctl
);

   localparam int DW   = ((COORD_BITS > 24) ? COORD_BITS : 24) + 1;
   localparam int MW   = DW + 21;
   localparam int YI_W = $clog2(MAX_ROWS + 1) + 1;
   localparam int ZI_W = $clog2(MAX_COLS + 1) + 1;
   localparam int FYW  = YI_W + 8;
   localparam int FZW  = ZI_W + 8;

   logic signed [DW-1:0] dy_ff, dz_ff, dy_in, dz_in;
   logic signed [MW-1:0] py_ff, pz_ff, py_in, pz_in;
   logic [19:0]          inv_h_eff, inv_w_eff;
   logic [YI_W-1:0]      rows_eff;
   logic [ZI_W-1:0]      cols_eff;
   logic signed [MW-1:0] y_lim, z_lim;
   logic signed [FYW-1:0] fy, gy;
   logic signed [FZW-1:0] fz, gz;
   logic signed [YI_W-1:0] ya_raw, yb_raw;
   logic signed [ZI_W-1:0] za_raw, zb_raw;
   logic [ROW_W-1:0]     ra, rb, rsel;
   logic [COL_W-1:0]     ca, cb, csel;

   assign dy_in = DW'($signed(qy)) - DW'($signed(cfg.y_origin));
   assign dz_in = DW'($signed(qz)) - DW'($signed(cfg.z_origin));

   always_ff @(posedge clock) begin
      if (en) begin
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
      end
   end

   // product of offset and cell reciprocal
   assign inv_h_eff = (cfg.inv_h == 20'd0) ? 20'd1 : cfg.inv_h;
   assign inv_w_eff = (cfg.inv_w == 20'd0) ? 20'd1 : cfg.inv_w;
   assign py_in = dy_ff * $signed({1'b0, inv_h_eff});
   assign pz_in = dz_ff * $signed({1'b0, inv_w_eff});

   always_comb begin
      if (cfg.rows == 7'd0) begin
         rows_eff = YI_W'(1);
      end else if (32'(cfg.rows) > 32'(MAX_ROWS)) begin
         rows_eff = YI_W'(MAX_ROWS);
      end else begin
         rows_eff = YI_W'(cfg.rows);
      end
      if (cfg.cols == 8'd0) begin
         cols_eff = ZI_W'(1);
      end else if (32'(cfg.cols) > 32'(MAX_COLS)) begin
         cols_eff = ZI_W'(MAX_COLS);
      end else begin
         cols_eff = ZI_W'(cfg.cols);
      end
   end

   assign y_lim  = MW'(rows_eff) <<< gsi_pkg::BOX_SHIFT;
   assign z_lim  = MW'(cols_eff) <<< gsi_pkg::BOX_SHIFT;
   assign in_box = !py_ff[MW-1] && !pz_ff[MW-1] && (py_ff <= y_lim) && (pz_ff <= z_lim);

   assign fy = py_ff[gsi_pkg::POS_SHIFT +: FYW];
   assign fz = pz_ff[gsi_pkg::POS_SHIFT +: FZW];
   assign gy = fy - FYW'(gsi_pkg::HALF_CELL);
   assign gz = fz - FZW'(gsi_pkg::HALF_CELL);

   always_comb begin
      if (cfg.mode == gsi_pkg::MODE_NEAREST) begin
         ya_raw = fy[FYW-1:8];
         za_raw = fz[FZW-1:8];
      end else begin
         ya_raw = gy[FYW-1:8];
         za_raw = gz[FZW-1:8];
      end
      yb_raw = gy[FYW-1:8] + YI_W'(1);
      zb_raw = gz[FZW-1:8] + ZI_W'(1);
   end

   // edge clamping
   always_comb begin
      if (ya_raw < 0) begin
         ra = '0;
      end else if ($unsigned(ya_raw) >= rows_eff) begin
         ra = ROW_W'(rows_eff - YI_W'(1));
      end else begin
         ra = ROW_W'($unsigned(ya_raw));
      end
      if (yb_raw < 0) begin
         rb = '0;
      end else if ($unsigned(yb_raw) >= rows_eff) begin
         rb = ROW_W'(rows_eff - YI_W'(1));
      end else begin
         rb = ROW_W'($unsigned(yb_raw));
      end
      if (za_raw < 0) begin
         ca = '0;
      end else if ($unsigned(za_raw) >= cols_eff) begin
         ca = COL_W'(cols_eff - ZI_W'(1));
      end else begin
         ca = COL_W'($unsigned(za_raw));
      end
      if (zb_raw < 0) begin
         cb = '0;
      end else if ($unsigned(zb_raw) >= cols_eff) begin
         cb = COL_W'(cols_eff - ZI_W'(1));
      end else begin
         cb = COL_W'($unsigned(zb_raw));
      end
   end

   // bank {p,q} holds rows of parity p and columns of parity q
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         rsel = (ra[0] == b[1]) ? ra : rb;
         csel = (ca[0] == b[0]) ? ca : cb;
         raddr[b] = {rsel[ROW_W-1:1], csel[COL_W-1:1]};
      end
   end

   assign ctl.nearest = (cfg.mode == gsi_pkg::MODE_NEAREST);
   assign ctl.ty      = gy[7:0];
   assign ctl.tz      = gz[7:0];
   assign ctl.ra_odd  = ra[0];
   assign ctl.rb_odd  = rb[0];
   assign ctl.ca_odd  = ca[0];
   assign ctl.cb_odd  = cb[0];

endmodule

// ===== hdl/gsi_grid.sv =====
module gsi_grid #(
   parameter int AW = 11,
   parameter int EW = 25
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic                 we,
   input  logic [1:0]           wbank,
   input  logic [AW-1:0]        waddr,
   input  logic [EW-1:0]        wdata,
   input  logic [3:0][AW-1:0]   raddr,
   output logic [3:0][EW-1:0]   rdata
);

   localparam int BANK_DEPTH = 2 ** AW;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [EW-1:0] mem [BANK_DEPTH];
      logic [EW-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (en) begin
            if (we && (wbank == 2'(b))) begin
               mem[waddr] <= wdata;
            end
            rd_ff <= mem[raddr[b]];
         end
      end

      assign rdata[b] = rd_ff;
   end

endmodule

// ===== hdl/gsi_blend.sv =====
module gsi_blend #(
   parameter int COORD_BITS = 24
) (
   input  logic                               clock,
   input  logic                               en,
   input  gsi_pkg::blend_ctl_type             ctl,
   input  logic [3:0][COORD_BITS:0]           rdata,
   output logic signed [COORD_BITS-1:0]       face_x,
   output logic                               face_ok
);

   localparam int CB  = COORD_BITS;
   localparam int PAW = CB + 10;
   localparam int BW  = PAW + 10;
   localparam int K   = CB + 3;
   localparam logic [K-1:0] RECIP3 = K'(((longint'(1) << K) + 2) / 3);

   logic signed [CB-1:0]  v [4];
   logic [3:0]            ok;
   logic [1:0]            bsel;
   logic signed [CB+1:0]  sum;
   logic [2:0]            cnt;
   logic signed [9:0]     wz0, wz1, wy0, wy1;

   logic signed [PAW-1:0] pa_ff, pb_ff, pa_in, pb_in;
   logic [CB:0]           abs_ff, abs_in, abs6_ff;
   logic                  neg_ff, neg6_ff, allv_ff, allv6_ff;
   logic [2:0]            cnt_ff, cnt6_ff;
   logic [7:0]            ty_ff;
   logic signed [BW-1:0]  bil_ff, bil_in;
   logic [CB+K:0]         q3_ff, q3_in;
   logic [CB:0]           mag;
   logic signed [CB+1:0]  mean;
   logic signed [CB-1:0]  face_x_ff, face_x_in;
   logic                  face_ok_ff, face_ok_in;

   // corner order: (ra,ca) (ra,cb) (rb,ca) (rb,cb)
   always_comb begin
      sum = '0;
      cnt = '0;
      for (int k = 0; k < 4; k++) begin
         bsel[1] = k[1] ? ctl.rb_odd : ctl.ra_odd;
         bsel[0] = k[0] ? ctl.cb_odd : ctl.ca_odd;
         v[k]    = rdata[bsel][CB-1:0];
         ok[k]   = rdata[bsel][CB] && ((k == 0) || !ctl.nearest);
         if (ok[k]) begin
            sum = sum + (CB+2)'(v[k]);
            cnt = cnt + 3'd1;
         end
      end
      abs_in = sum[CB+1] ? (CB+1)'(0) - sum[CB:0] : sum[CB:0];
   end

   assign wz1   = $signed({2'b00, ctl.tz});
   assign wz0   = 10'sd256 - wz1;
   assign pa_in = wz0 * v[0] + wz1 * v[1];
   assign pb_in = wz0 * v[2] + wz1 * v[3];

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         abs_ff  <= abs_in;
         neg_ff  <= sum[CB+1];
         cnt_ff  <= cnt;
         allv_ff <= &ok;
         ty_ff   <= ctl.ty;
      end
   end

   assign wy1    = $signed({2'b00, ty_ff});
   assign wy0    = 10'sd256 - wy1;
   assign bil_in = wy0 * pa_ff + wy1 * pb_ff;
   assign q3_in  = abs_ff * RECIP3;

   always_ff @(posedge clock) begin
      if (en) begin
         bil_ff   <= bil_in;
         q3_ff    <= q3_in;
         abs6_ff  <= abs_ff;
         neg6_ff  <= neg_ff;
         cnt6_ff  <= cnt_ff;
         allv6_ff <= allv_ff;
      end
   end

   // mean of valid corners, truncated toward zero
   always_comb begin
      unique case (cnt6_ff)
         3'd1:    mag = abs6_ff;
         3'd2:    mag = abs6_ff >> 1;
         3'd3:    mag = (CB+1)'(q3_ff >> K);
         3'd4:    mag = abs6_ff >> 2;
         default: mag = '0;
      endcase
      mean = neg6_ff ? (CB+2)'(0) - (CB+2)'(mag) : (CB+2)'(mag);
      if (allv6_ff) begin
         face_x_in  = bil_ff[gsi_pkg::POS_SHIFT +: CB];
         face_ok_in = 1'b1;
      end else begin
         face_x_in  = mean[CB-1:0];
         face_ok_in = (cnt6_ff != 3'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         face_x_ff  <= face_x_in;
         face_ok_ff <= face_ok_in;
      end
   end

   assign face_x  = face_x_ff;
   assign face_ok = face_ok_ff;

endmodule

// ===== hdl/gsi_checker.sv =====
`include "grid_surface_interpolator_unit_assert.svh"

module gsi_checker #(
   parameter int COORD_BITS = 24
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_in_box,
   input logic                         rsp_neg_face_valid,
   input logic                         rsp_pos_face_valid,
   input logic signed [COORD_BITS-1:0] rsp_mid_x,
   input logic                         rsp_contained,
   input logic                         rsp_no_data_error
);

   // stalled result holds
   `GSI_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mid_x), "stalled result changed")

   // input is held back only by a waiting result
   `GSI_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "req_stall without output backpressure")

   // outside the box nothing is reported
   `GSI_ASSERT(a_out_of_box, clock, reset, rsp_valid && !rsp_in_box |-> !rsp_neg_face_valid && !rsp_pos_face_valid && !rsp_contained && !rsp_no_data_error, "out of box result not empty")

   // error only when a face is missing inside the box
   `GSI_ASSERT(a_err_cause, clock, reset, rsp_valid && rsp_no_data_error |-> rsp_in_box && !(rsp_neg_face_valid && rsp_pos_face_valid) && !rsp_contained, "no data error without missing face")

   // reset empties the output
   `GSI_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind grid_surface_interpolator_unit gsi_checker #(.COORD_BITS(COORD_BITS)) u_gsi_checker (.*);

// ===== sim/tb_grid_surface_interpolator_unit.sv =====
module tb_grid_surface_interpolator_unit;

   localparam int NROW = 64;
   localparam int NCOL = 128;
   localparam longint CMAX = 8388607;
   localparam longint CMIN = -8388608;

   typedef struct packed {
      logic              in_box;
      logic signed [23:0] neg_x;
      logic              neg_ok;
      logic signed [23:0] pos_x;
      logic              pos_ok;
      logic signed [23:0] mid_x;
      logic signed [24:0] gap;
      logic              contained;
      logic              err;
   } surface_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = gsi_pkg::OP_LOAD;
   logic req_face_select = gsi_pkg::FACE_NEG;
   logic [5:0] req_load_row = '0;
   logic [6:0] req_load_col = '0;
   logic signed [23:0] req_load_value = '0;
   logic req_load_has_data = 1'b0;
   logic signed [23:0] req_query_y = '0;
   logic signed [23:0] req_query_z = '0;
   logic signed [23:0] req_query_x = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_in_box;
   logic signed [23:0] rsp_neg_face_x;
   logic rsp_neg_face_valid;
   logic signed [23:0] rsp_pos_face_x;
   logic rsp_pos_face_valid;
   logic signed [23:0] rsp_mid_x;
   logic signed [24:0] rsp_face_gap;
   logic rsp_contained;
   logic rsp_no_data_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [gsi_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [gsi_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic [24:0] neg_grid [NROW*NCOL];
   logic [24:0] pos_grid [NROW*NCOL];
   logic signed [23:0] y_org, z_org;
   logic [19:0] inv_h, inv_w;
   logic [6:0] rows_cfg;
   logic [7:0] cols_cfg;
   logic mode_cfg;
   logic [1:0] policy_cfg;

   surface_result_type pending_results [$];
   int errors = 0;
   int n_queries = 0;
   int n_loads = 0;
   int n_checked = 0;
   int n_settings = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   grid_surface_interpolator_unit u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40000000;
      $display("tb_grid_surface_interpolator_unit: FAIL");
      $finish;
   end

   function automatic longint clamp_idx(longint i, longint n);
      if (i < 0) return 0;
      if (i > n - 1) return n - 1;
      return i;
   endfunction

   function automatic bit read_cell(bit face, longint r, longint c, output longint v);
      logic [24:0] ent;
      ent = face ? pos_grid[r*NCOL + c] : neg_grid[r*NCOL + c];
      v = longint'(signed'(ent[23:0]));
      return ent[24];
   endfunction

   function automatic bit sample_face(bit face, longint fy, longint fz, longint rows,
                                      longint cols, output longint v);
      longint cv [4];
      bit ok [4];
      longint gy, gz, y0, z0, y1, z1, ty, tz, sum;
      int n;
      v = 0;
      if (mode_cfg == gsi_pkg::MODE_NEAREST) begin
         if (!read_cell(face, clamp_idx(fy >>> 8, rows), clamp_idx(fz >>> 8, cols), v)) begin
            v = 0;
            return 0;
         end
         return 1;
      end
      gy = fy - gsi_pkg::HALF_CELL;
      gz = fz - gsi_pkg::HALF_CELL;
      y0 = gy >>> 8;
      z0 = gz >>> 8;
      ty = gy - y0 * gsi_pkg::WEIGHT_ONE;
      tz = gz - z0 * gsi_pkg::WEIGHT_ONE;
      y1 = clamp_idx(y0 + 1, rows);
      z1 = clamp_idx(z0 + 1, cols);
      y0 = clamp_idx(y0, rows);
      z0 = clamp_idx(z0, cols);
      ok[0] = read_cell(face, y0, z0, cv[0]);
      ok[1] = read_cell(face, y0, z1, cv[1]);
      ok[2] = read_cell(face, y1, z0, cv[2]);
      ok[3] = read_cell(face, y1, z1, cv[3]);
      if (!(ok[0] && ok[1] && ok[2] && ok[3])) begin
         sum = 0;
         n = 0;
         for (int k = 0; k < 4; k++)
            if (ok[k]) begin
               sum += cv[k];
               n++;
            end
         if (n == 0) return 0;
         v = sum / n;
         return 1;
      end
      sum = (256 - ty) * ((256 - tz) * cv[0] + tz * cv[1])
          + ty * ((256 - tz) * cv[2] + tz * cv[3]);
      v = sum >>> gsi_pkg::POS_SHIFT;
      return 1;
   endfunction

   function automatic longint rows_eff();
      return rows_cfg == 0 ? 1 : (rows_cfg > NROW ? NROW : rows_cfg);
   endfunction

   function automatic longint cols_eff();
      return cols_cfg == 0 ? 1 : (cols_cfg > NCOL ? NCOL : cols_cfg);
   endfunction

   function automatic surface_result_type predict_query(logic signed [23:0] qy,
                                                        logic signed [23:0] qz,
                                                        logic signed [23:0] qx);
      surface_result_type e;
      longint rows, cols, py, pz, nx, px;
      bit nv, pv;
      e = '0;
      rows = rows_eff();
      cols = cols_eff();
      py = (longint'(qy) - longint'(y_org)) * (inv_h == 0 ? 1 : longint'(inv_h));
      pz = (longint'(qz) - longint'(z_org)) * (inv_w == 0 ? 1 : longint'(inv_w));
      e.in_box = py >= 0 && pz >= 0 && py <= rows * (64'sd1 << gsi_pkg::BOX_SHIFT)
                 && pz <= cols * (64'sd1 << gsi_pkg::BOX_SHIFT);
      if (e.in_box) begin
         nv = sample_face(gsi_pkg::FACE_NEG, py >>> gsi_pkg::POS_SHIFT,
                          pz >>> gsi_pkg::POS_SHIFT, rows, cols, nx);
         pv = sample_face(gsi_pkg::FACE_POS, py >>> gsi_pkg::POS_SHIFT,
                          pz >>> gsi_pkg::POS_SHIFT, rows, cols, px);
         e.neg_x = nx[23:0];
         e.neg_ok = nv;
         e.pos_x = px[23:0];
         e.pos_ok = pv;
         if (nv && pv) begin
            e.mid_x = 24'((nx + px) / 2);
            e.gap = 25'(px - nx);
            e.contained = longint'(qx) >= nx && longint'(qx) <= px;
         end else if (policy_cfg == gsi_pkg::POLICY_INSIDE) begin
            e.contained = qx >= -gsi_pkg::INSIDE_HALF && qx <= gsi_pkg::INSIDE_HALF;
         end else if (policy_cfg == gsi_pkg::POLICY_ERROR) begin
            e.err = 1'b1;
         end
      end
      return e;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      surface_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with no query pending", $time);
         end else begin
            e = pending_results.pop_front();
            n_checked++;
            check_field("in_box", e.in_box, rsp_in_box);
            check_field("neg_face_x", e.neg_x, rsp_neg_face_x);
            check_field("neg_face_valid", e.neg_ok, rsp_neg_face_valid);
            check_field("pos_face_x", e.pos_x, rsp_pos_face_x);
            check_field("pos_face_valid", e.pos_ok, rsp_pos_face_valid);
            check_field("mid_x", e.mid_x, rsp_mid_x);
            check_field("face_gap", e.gap, rsp_face_gap);
            check_field("contained", e.contained, rsp_contained);
            check_field("no_data_error", e.err, rsp_no_data_error);
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic send_item(logic op, logic face, logic [5:0] row, logic [6:0] col,
                            logic signed [23:0] val, logic has, logic signed [23:0] qy,
                            logic signed [23:0] qz, logic signed [23:0] qx);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_face_select <= face;
      req_load_row <= row;
      req_load_col <= col;
      req_load_value <= val;
      req_load_has_data <= has;
      req_query_y <= qy;
      req_query_z <= qz;
      req_query_x <= qx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == gsi_pkg::OP_LOAD) begin
         n_loads++;
         if (face == gsi_pkg::FACE_POS) pos_grid[row*NCOL + col] = {has, val};
         else neg_grid[row*NCOL + col] = {has, val};
      end else begin
         n_queries++;
         pending_results.push_back(predict_query(qy, qz, qx));
      end
   endtask

   task automatic load_cell(logic face, int row, int col, longint val, logic has);
      send_item(gsi_pkg::OP_LOAD, face, row[5:0], col[6:0], val[23:0], has, 24'($urandom),
                24'($urandom), 24'($urandom));
   endtask

   task automatic query_point(longint qy, longint qz, longint qx);
      send_item(gsi_pkg::OP_QUERY, 1'($urandom), 6'($urandom), 7'($urandom), 24'($urandom),
                1'($urandom), qy[23:0], qz[23:0], qx[23:0]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [gsi_pkg::CSR_INDEX_W-1:0] idx, longint val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[23:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      unique case (idx)
         gsi_pkg::REG_Y_ORIGIN: y_org = val[23:0];
         gsi_pkg::REG_Z_ORIGIN: z_org = val[23:0];
         gsi_pkg::REG_INV_CELL_H: inv_h = val[19:0];
         gsi_pkg::REG_INV_CELL_W: inv_w = val[19:0];
         gsi_pkg::REG_ROWS_IN_USE: rows_cfg = val[6:0];
         gsi_pkg::REG_COLS_IN_USE: cols_cfg = val[7:0];
         gsi_pkg::REG_INTERP_MODE: mode_cfg = val[0];
         gsi_pkg::REG_NO_DATA_POLICY: policy_cfg = val[1:0];
      endcase
   endtask

   task automatic set_geometry(longint oy, longint oz, longint ih, longint iw, longint rows,
                               longint cols, logic mode, logic [1:0] policy);
      wait_drained();
      write_reg(gsi_pkg::REG_Y_ORIGIN, oy);
      write_reg(gsi_pkg::REG_Z_ORIGIN, oz);
      write_reg(gsi_pkg::REG_INV_CELL_H, ih);
      write_reg(gsi_pkg::REG_INV_CELL_W, iw);
      write_reg(gsi_pkg::REG_ROWS_IN_USE, rows);
      write_reg(gsi_pkg::REG_COLS_IN_USE, cols);
      write_reg(gsi_pkg::REG_INTERP_MODE, longint'(mode));
      write_reg(gsi_pkg::REG_NO_DATA_POLICY, longint'(policy));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   function automatic longint face_value();
      unique case ($urandom_range(0, 9))
         0: return longint'(signed'(24'($urandom)));
         1: return $urandom_range(0, 1) ? CMAX : CMIN;
         default: return longint'($urandom_range(0, 4000)) - 2000;
      endcase
   endfunction

   task automatic fill_region();
      for (int r = 0; r < rows_eff(); r++)
         for (int c = 0; c < cols_eff(); c++) begin
            load_cell(gsi_pkg::FACE_NEG, r, c, face_value(), $urandom_range(0, 9) != 0);
            load_cell(gsi_pkg::FACE_POS, r, c, face_value(), $urandom_range(0, 9) != 0);
         end
   endtask

   function automatic longint sat_coord(longint v);
      return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
   endfunction

   function automatic longint pick_coord(longint org, longint inv, longint n);
      longint span;
      span = (n << gsi_pkg::BOX_SHIFT) / (inv == 0 ? 1 : inv);
      unique case ($urandom_range(0, 9))
         0: return longint'(signed'(24'($urandom)));
         1: return sat_coord(org + ($urandom_range(0, 1) ? span + $urandom_range(0, 3)
                                                        : -longint'($urandom_range(0, 3))));
         default: return sat_coord(org + longint'({$urandom, $urandom} % (span + 1)));
      endcase
   endfunction

   function automatic longint pick_x();
      unique case ($urandom_range(0, 7))
         0: return longint'(signed'(24'($urandom)));
         1: return longint'($urandom_range(0, 3)) + gsi_pkg::INSIDE_HALF - 1;
         2: return -longint'($urandom_range(0, 3)) - gsi_pkg::INSIDE_HALF + 1;
         default: return longint'($urandom_range(0, 5000)) - 2500;
      endcase
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            load_cell(1'($urandom_range(0, 1)), $urandom_range(0, NROW - 1),
                      $urandom_range(0, NCOL - 1), face_value(), $urandom_range(0, 4) != 0);
         else
            query_point(pick_coord(y_org, inv_h, rows_eff()),
                        pick_coord(z_org, inv_w, cols_eff()), pick_x());
      end
   endtask

   task automatic test_directed();
      set_geometry(0, 0, 65536, 65536, 2, 2, gsi_pkg::MODE_BILINEAR, gsi_pkg::POLICY_OUTSIDE);
      load_cell(gsi_pkg::FACE_NEG, 0, 0, 100, 1'b1);
      load_cell(gsi_pkg::FACE_NEG, 0, 1, 300, 1'b1);
      load_cell(gsi_pkg::FACE_NEG, 1, 0, CMIN, 1'b1);
      load_cell(gsi_pkg::FACE_NEG, 1, 1, CMAX, 1'b1);
      load_cell(gsi_pkg::FACE_POS, 0, 0, 1000, 1'b1);
      load_cell(gsi_pkg::FACE_POS, 0, 1, -7, 1'b1);
      load_cell(gsi_pkg::FACE_POS, 1, 0, 0, 1'b0);
      load_cell(gsi_pkg::FACE_POS, 1, 1, 5, 1'b0);
      for (int m = 0; m < 2; m++) begin
         set_geometry(0, 0, 65536, 65536, 2, 2, m[0], gsi_pkg::POLICY_OUTSIDE);
         query_point(0, 0, 100);
         query_point(512, 512, CMAX);
         query_point(-1, 100, 0);
         query_point(100, 513, 0);
         query_point(200, 300, 150);
         query_point(128, 128, CMIN);
      end
      load_cell(gsi_pkg::FACE_POS, 0, 0, 0, 1'b0);
      load_cell(gsi_pkg::FACE_POS, 0, 1, 0, 1'b0);
      for (int p = 1; p < 4; p++) begin
         set_geometry(0, 0, 65536, 65536, 2, 2, gsi_pkg::MODE_BILINEAR, p[1:0]);
         query_point(10, 10, gsi_pkg::INSIDE_HALF);
         query_point(10, 10, -gsi_pkg::INSIDE_HALF - 1);
      end
   endtask

   task automatic test_extremes();
      set_geometry(CMIN, CMAX, 1, 1048575, 64, 1, gsi_pkg::MODE_BILINEAR,
                   gsi_pkg::POLICY_INSIDE);
      fill_region();
      random_items(40);
      set_geometry(CMAX, CMIN, 1048575, 1, 1, 128, gsi_pkg::MODE_NEAREST,
                   gsi_pkg::POLICY_ERROR);
      fill_region();
      random_items(40);
      set_geometry(-300, 500, 0, 0, 0, 0, gsi_pkg::MODE_BILINEAR, 2'd3);
      fill_region();
      random_items(30);
      // same cells as the first setting, already loaded
      set_geometry(1000, -1000, 30000, 200000, 127, 1, gsi_pkg::MODE_NEAREST,
                   gsi_pkg::POLICY_OUTSIDE);
      random_items(30);
      // same cells as the second setting, already loaded
      set_geometry(0, 0, 65536, 65536, 1, 255, gsi_pkg::MODE_BILINEAR, gsi_pkg::POLICY_ERROR);
      random_items(30);
   endtask

   task automatic test_random_phases();
      int idles [4] = '{0, 88, 0, 8};
      int stalls [4] = '{0, 0, 88, 8};
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idles[ph];
         stall_pct = stalls[ph];
         for (int s = 0; s < 2; s++) begin
            set_geometry(longint'($urandom_range(0, 20000)) - 10000,
                         longint'($urandom_range(0, 20000)) - 10000,
                         $urandom_range(16384, 262144), $urandom_range(16384, 262144),
                         $urandom_range(1, 6), $urandom_range(1, 6),
                         1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            fill_region();
            random_items(22);
            if (ph == 3 && s == 1) begin
               while (pending_results.size() != 0) begin
                  req_valid <= 1'b0;
                  @(posedge clock);
               end
            end
            random_items(22);
         end
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      for (int i = 0; i < NROW*NCOL; i++) begin
         neg_grid[i] = '0;
         pos_grid[i] = '0;
      end
      y_org = '0;
      z_org = '0;
      inv_h = 20'd65536;
      inv_w = 20'd65536;
      rows_cfg = 7'd64;
      cols_cfg = 8'd128;
      mode_cfg = gsi_pkg::MODE_BILINEAR;
      policy_cfg = gsi_pkg::POLICY_OUTSIDE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_extremes();
      test_random_phases();
      wait_drained();
      $display("covered %0d loads and %0d queries (%0d results checked) over %0d settings",
               n_loads, n_queries, n_checked, n_settings);
      $display("nearest and bilinear lookup, missing corners, all no-data policies, idle/stall");
      if (errors == 0 && pending_results.size() == 0)
         $display("tb_grid_surface_interpolator_unit: PASS");
      else
         $display("tb_grid_surface_interpolator_unit: FAIL");
      $finish;
   end

endmodule
